FILE: src/rmd160_pkg.sv
package rmd160_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PREP,
    ST_STEP,
    ST_FINAL,
    ST_EMIT
  } state_t;

  localparam int unsigned STEPS     = 80;
  localparam int unsigned LAST_STEP = STEPS - 1;

  // Initial chaining values
  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Message word selection per step
  localparam logic [3:0] SEL_LEFT [STEPS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
  };

  localparam logic [3:0] SEL_RIGHT [STEPS] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
  };

  // Rotate amounts per step
  localparam logic [3:0] ROT_LEFT [STEPS] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
    4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
    4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
    4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
    4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
    4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
    4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6
  };

  localparam logic [3:0] ROT_RIGHT [STEPS] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
    4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
    4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
    4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
    4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
    4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
    4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11
  };

  // Round constants, left line
  function automatic logic [31:0] k_left(input logic [2:0] round);
    unique case (round)
      3'd0:    return 32'h00000000;
      3'd1:    return 32'h5a827999;
      3'd2:    return 32'h6ed9eba1;
      3'd3:    return 32'h8f1bbcdc;
      default: return 32'ha953fd4e;
    endcase
  endfunction

  // Round constants, right line
  function automatic logic [31:0] k_right(input logic [2:0] round);
    unique case (round)
      3'd0:    return 32'h50a28be6;
      3'd1:    return 32'h5c4dd124;
      3'd2:    return 32'h6d703ef3;
      3'd3:    return 32'h7a6d76e9;
      default: return 32'h00000000;
    endcase
  endfunction

  // Boolean function of a round
  function automatic logic [31:0] boolfn(input logic [2:0] round, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
    unique case (round)
      3'd0:    return x ^ y ^ z;
      3'd1:    return (x & y) | (~x & z);
      3'd2:    return (x | ~y) ^ z;
      3'd3:    return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  // Rotate left, amount 0..31
  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} << s;
    return d[63:32];
  endfunction

endpackage

FILE: src/ripemd160_hash_engine_top.sv
// RIPEMD-160 hasher, one word transaction per cycle while the block buffer fills.
// A 16th word starts a compression: a load, 80 steps of the two-line step unit
// (both lines in parallel), a fold. A last word adds its padding words, written
// one by one, and a compression per padded block; the five digest words then go
// out one per cycle while digest_stall is low. Synchronous active-high reset loads
// the initial chaining values and clears the bit count and fill position.
module ripemd160_hash_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_last
);

  rmd160_pkg::state_t state, state_next;

  logic [31:0] chain [5];
  logic [31:0] wl [5];
  logic [31:0] wr [5];
  logic [31:0] mem [16];
  logic [31:0] rd_l, rd_r;
  logic [31:0] pad_word;
  logic [63:0] bit_count;
  logic [3:0]  fill;
  logic [6:0]  step;
  logic [2:0]  out_idx;
  logic        finishing, pad_written, len_lo, len_hi;

  logic        accept;
  logic [2:0]  n_sat;
  logic [31:0] mask;
  logic [31:0] padw;
  logic        wr_en;
  logic [31:0] wr_data;
  logic [6:0]  rd_idx;
  logic [2:0]  round_l, round_r;
  logic [31:0] sum_l, sum_r, t_l, t_r;

  assign accept = data_valid && !data_stall;

  // Last-word byte handling
  always_comb begin
    n_sat = (byte_count > 3'd4) ? 3'd4 : byte_count;
    unique case (n_sat[1:0])
      2'd0:    mask = 32'h00000000;
      2'd1:    mask = 32'h000000ff;
      2'd2:    mask = 32'h0000ffff;
      default: mask = 32'h00ffffff;
    endcase
    if (n_sat == 3'd4) begin
      padw = 32'h00000080;
    end else begin
      padw = (data_word & mask) | (32'h00000080 << {n_sat[1:0], 3'b000});
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rmd160_pkg::ST_IDLE: begin
        if (accept) begin
          if ((!last_word || n_sat == 3'd4) && fill == 4'd15) begin
            state_next = rmd160_pkg::ST_PREP;
          end else if (last_word) begin
            state_next = rmd160_pkg::ST_PAD;
          end
        end
      end
      rmd160_pkg::ST_PAD: begin
        if (fill == 4'd15) begin
          state_next = rmd160_pkg::ST_PREP;
        end
      end
      rmd160_pkg::ST_PREP: state_next = rmd160_pkg::ST_STEP;
      rmd160_pkg::ST_STEP: begin
        if (step == 7'(rmd160_pkg::LAST_STEP)) begin
          state_next = rmd160_pkg::ST_FINAL;
        end
      end
      rmd160_pkg::ST_FINAL: begin
        if (finishing && len_hi) begin
          state_next = rmd160_pkg::ST_EMIT;
        end else if (finishing) begin
          state_next = rmd160_pkg::ST_PAD;
        end else begin
          state_next = rmd160_pkg::ST_IDLE;
        end
      end
      rmd160_pkg::ST_EMIT: begin
        if (!digest_stall && out_idx == 3'd4) begin
          state_next = rmd160_pkg::ST_IDLE;
        end
      end
      default: state_next = rmd160_pkg::ST_IDLE;
    endcase
  end

  // Outputs and buffer port control
  always_comb begin
    data_stall   = 1'b1;
    digest_valid = 1'b0;
    wr_en        = 1'b0;
    wr_data      = data_word;
    rd_idx       = 7'd0;
    unique case (state)
      rmd160_pkg::ST_IDLE: begin
        // input never stalled here, so valid alone marks a transaction
        data_stall = 1'b0;
        wr_en      = data_valid && (!last_word || n_sat == 3'd4);
      end
      rmd160_pkg::ST_PAD: begin
        wr_en = 1'b1;
        if (!pad_written) begin
          wr_data = pad_word;
        end else if (fill == 4'd14) begin
          wr_data = bit_count[31:0];
        end else if (fill == 4'd15 && len_lo) begin
          wr_data = bit_count[63:32];
        end else begin
          wr_data = 32'h0;
        end
      end
      rmd160_pkg::ST_STEP: begin
        rd_idx = (step == 7'(rmd160_pkg::LAST_STEP)) ? 7'd0 : 7'(step + 7'd1);
      end
      rmd160_pkg::ST_EMIT: digest_valid = 1'b1;
      default: ;
    endcase
  end

  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign digest_last = (out_idx == 3'd4);

  // Block buffer: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill] <= wr_data;
    end
    rd_l <= mem[rmd160_pkg::SEL_LEFT[rd_idx]];
    rd_r <= mem[rmd160_pkg::SEL_RIGHT[rd_idx]];
  end

  // Step unit, computing both lines in parallel
  always_comb begin
    round_l = step[6:4];
    round_r = 3'd4 - step[6:4];
    sum_l = wl[0] + rmd160_pkg::boolfn(round_l, wl[1], wl[2], wl[3]) + rd_l
            + rmd160_pkg::k_left(round_l);
    sum_r = wr[0] + rmd160_pkg::boolfn(round_r, wr[1], wr[2], wr[3]) + rd_r
            + rmd160_pkg::k_right(round_l);
    t_l = rmd160_pkg::rotl(sum_l, {1'b0, rmd160_pkg::ROT_LEFT[step]}) + wl[4];
    t_r = rmd160_pkg::rotl(sum_r, {1'b0, rmd160_pkg::ROT_RIGHT[step]}) + wr[4];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state == rmd160_pkg::ST_IDLE && accept && last_word) begin
      pad_word <= padw;
    end
    if (state == rmd160_pkg::ST_PREP) begin
      for (int i = 0; i < 5; i++) begin
        wl[i] <= chain[i];
        wr[i] <= chain[i];
      end
    end else if (state == rmd160_pkg::ST_STEP) begin
      wl[0] <= wl[4];
      wl[4] <= wl[3];
      wl[3] <= rmd160_pkg::rotl(wl[2], 5'd10);
      wl[2] <= wl[1];
      wl[1] <= t_l;
      wr[0] <= wr[4];
      wr[4] <= wr[3];
      wr[3] <= rmd160_pkg::rotl(wr[2], 5'd10);
      wr[2] <= wr[1];
      wr[1] <= t_r;
    end
  end

  // Control state, counters and chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rmd160_pkg::ST_IDLE;
      fill        <= 4'd0;
      bit_count   <= 64'd0;
      step        <= 7'd0;
      out_idx     <= 3'd0;
      finishing   <= 1'b0;
      pad_written <= 1'b0;
      len_lo      <= 1'b0;
      len_hi      <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        chain[i] <= rmd160_pkg::IV[i];
      end
    end else begin
      state <= state_next;
      if (wr_en) begin
        fill <= 4'(fill + 4'd1);
      end
      if (state == rmd160_pkg::ST_IDLE && accept) begin
        if (last_word) begin
          bit_count <= bit_count + {58'd0, n_sat, 3'b000};
          finishing <= 1'b1;
        end else begin
          bit_count <= bit_count + 64'd32;
        end
      end
      // padding progress flags
      if (state == rmd160_pkg::ST_PAD) begin
        pad_written <= 1'b1;
        if (pad_written && fill == 4'd14) begin
          len_lo <= 1'b1;
        end
        if (pad_written && fill == 4'd15 && len_lo) begin
          len_hi <= 1'b1;
        end
      end
      if (state == rmd160_pkg::ST_PREP) begin
        step <= 7'd0;
      end else if (state == rmd160_pkg::ST_STEP) begin
        step <= 7'(step + 7'd1);
      end
      // fold the two lines into the chaining words
      if (state == rmd160_pkg::ST_FINAL) begin
        chain[0] <= chain[1] + wl[2] + wr[3];
        chain[1] <= chain[2] + wl[3] + wr[4];
        chain[2] <= chain[3] + wl[4] + wr[0];
        chain[3] <= chain[4] + wl[0] + wr[1];
        chain[4] <= chain[0] + wl[1] + wr[2];
        out_idx  <= 3'd0;
      end
      // digest transactions, then back to a fresh message
      if (state == rmd160_pkg::ST_EMIT && !digest_stall) begin
        if (out_idx == 3'd4) begin
          out_idx     <= 3'd0;
          bit_count   <= 64'd0;
          fill        <= 4'd0;
          finishing   <= 1'b0;
          pad_written <= 1'b0;
          len_lo      <= 1'b0;
          len_hi      <= 1'b0;
          for (int i = 0; i < 5; i++) begin
            chain[i] <= rmd160_pkg::IV[i];
          end
        end else begin
          out_idx <= 3'(out_idx + 3'd1);
        end
      end
    end
  end

  // Checks
  a_no_input_while_emit: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> data_stall)
    else $error("input taken while digest pending");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == rmd160_pkg::ST_STEP) |-> (step <= 7'(rmd160_pkg::LAST_STEP)))
    else $error("step counter out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (out_idx <= 3'd4))
    else $error("digest index out of range");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && last_word) |=> (data_stall && finishing))
    else $error("last word did not start padding");

  a_compress_on_full: assert property (@(posedge clk) disable iff (rst)
    (wr_en && fill == 4'd15) |=> (state == rmd160_pkg::ST_PREP))
    else $error("full block not compressed");

endmodule
